[src/acp_pkg.sv]
// Shared types and constants for the arithmetic composite pixel block.
`default_nettype none

package acp_pkg;

  // Pixel and coefficient geometry
  localparam int CH_W           = 8;
  localparam int NUM_LANES      = 4;
  localparam int ALPHA_LANE     = 3;
  localparam int PIX_W          = CH_W * NUM_LANES;
  localparam int COEF_W         = 32;
  localparam int COEF_FRAC_BITS = 16;
  localparam int CFG_IDX_W      = 3;

  // Datapath widths: products hold 17 x 32 bits, the sum of four terms needs two more
  localparam int PROD_W = 50;
  localparam int SUM_W  = 52;

  // Register stages inside one lane, counted after the entry register
  localparam int LANE_STAGES = 7;

  // Formula constants
  localparam logic signed [PROD_W-1:0] K_SQ      = PROD_W'(65025);
  localparam logic signed [SUM_W-1:0]  ROUND_HALF = SUM_W'(255) << (COEF_FRAC_BITS - 1);
  localparam logic [15:0]              CLAMP_T   = 16'd65280;
  localparam logic [CH_W-1:0]          CH_MAX    = 8'd255;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_COEF_PRODUCT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_SECOND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_OFFSET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_MODE  = 3'd4;

  // Word operation codes
  typedef enum logic [1:0] {
    OP_PIXEL     = 2'd0,
    OP_LOAD_LIN  = 2'd1,
    OP_LOAD_SRGB = 2'd2
  } op_t;

  // Blend coefficients
  typedef struct packed {
    logic signed [COEF_W-1:0] k1;
    logic signed [COEF_W-1:0] k2;
    logic signed [COEF_W-1:0] k3;
    logic signed [COEF_W-1:0] k4;
  } coef_t;

  // Pipeline control shared by all lanes
  typedef struct packed {
    logic [LANE_STAGES-1:0] load;
    logic                   lin_we;
    logic [CH_W-1:0]        lin_idx;
    logic [CH_W-1:0]        lin_val;
    logic                   srgb_we;
    logic [CH_W-1:0]        srgb_idx;
    logic [CH_W-1:0]        srgb_val;
  } lane_ctl_t;

endpackage

`default_nettype wire

[src/acp_lane.sv]
// One channel lane: table lookups, blend products, sum, scaling and clamp.
`default_nettype none

module acp_lane (
  input  wire logic                    clk,
  input  wire acp_pkg::lane_ctl_t      ctl,
  input  wire acp_pkg::coef_t          coef,
  input  wire logic                    lin_en,
  input  wire logic [acp_pkg::CH_W-1:0] a_in,
  input  wire logic [acp_pkg::CH_W-1:0] b_in,
  output logic [acp_pkg::CH_W-1:0]     res
);
  import acp_pkg::*;

  logic [CH_W-1:0] lin_mem  [256];
  logic [CH_W-1:0] srgb_mem [256];

  logic [CH_W-1:0] a1, b1, la1, lb1;
  logic [CH_W-1:0] ma, mb;
  logic [2*CH_W-1:0] ab2, a255_2, b255_2;
  logic signed [PROD_W-1:0] ab_x, a_x, b_x, k1_x, k2_x, k3_x, k4_x;
  logic signed [PROD_W-1:0] p1, p2, p3, p4;
  logic signed [SUM_W-1:0] s01, s23, s5;
  logic [SUM_W-1:0] t;
  logic pos, big;
  logic [16:0] d;
  logic [CH_W-1:0] q6, q7, srgb_rd;

  // Stage 1: to-linear table, read and written in word order
  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      a1  <= a_in;
      b1  <= b_in;
      la1 <= lin_mem[a_in];
      lb1 <= lin_mem[b_in];
    end
    if (ctl.lin_we) begin
      lin_mem[ctl.lin_idx] <= ctl.lin_val;
    end
  end

  // Stage 2: pick mapped or raw values, small products
  always_comb begin
    ma = lin_en ? la1 : a1;
    mb = lin_en ? lb1 : b1;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      ab2    <= {8'd0, ma} * {8'd0, mb};
      a255_2 <= {ma, 8'd0} - {8'd0, ma};
      b255_2 <= {mb, 8'd0} - {8'd0, mb};
    end
  end

  // Stage 3: coefficient products
  always_comb begin
    ab_x = PROD_W'($signed({1'b0, ab2}));
    a_x  = PROD_W'($signed({1'b0, a255_2}));
    b_x  = PROD_W'($signed({1'b0, b255_2}));
    k1_x = PROD_W'(coef.k1);
    k2_x = PROD_W'(coef.k2);
    k3_x = PROD_W'(coef.k3);
    k4_x = PROD_W'(coef.k4);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      p1 <= ab_x * k1_x;
      p2 <= a_x * k2_x;
      p3 <= b_x * k3_x;
      p4 <= k4_x * K_SQ;
    end
  end

  // Stages 4 and 5: sum of the four terms plus rounding half
  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      s01 <= SUM_W'(p1) + SUM_W'(p2);
      s23 <= SUM_W'(p3) + SUM_W'(p4) + ROUND_HALF;
    end
    if (ctl.load[4]) begin
      s5 <= s01 + s23;
    end
  end

  // Stage 6: drop fraction, divide by 255, clamp to 0..255
  always_comb begin
    pos = !s5[SUM_W-1] && (s5 != '0);
    t   = $unsigned(s5) >> COEF_FRAC_BITS;
    big = (t[SUM_W-1:16] != '0) || (t[15:0] >= CLAMP_T);
    // exact x/255 for x below 65280
    d   = {1'b0, t[15:0]} + {9'd0, t[15:8]} + 17'd1;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[5]) begin
      if (!pos) begin
        q6 <= '0;
      end else if (big) begin
        q6 <= CH_MAX;
      end else begin
        q6 <= d[15:8];
      end
    end
  end

  // Stage 7: to-sRGB table, written at the same stage it is read
  always_ff @(posedge clk) begin
    if (ctl.load[6]) begin
      q7      <= q6;
      srgb_rd <= srgb_mem[q6];
    end
    if (ctl.srgb_we) begin
      srgb_mem[ctl.srgb_idx] <= ctl.srgb_val;
    end
  end

  assign res = lin_en ? srgb_rd : q7;

endmodule

`default_nettype wire

[src/arithmetic_composite_pixel.sv]
// Top level: entry register, pipeline control, four channel lanes and output merge.
`default_nettype none

// Arithmetic compositing of two 32-bit pixels, one word per clock. Each of the
// four 8-bit channels runs in its own lane; the three colour lanes can map
// through loadable to-linear and to-sRGB tables (256 x 8 each, contents
// undefined until loaded; every lane keeps its own copy, and a load word writes
// all copies). The accepting edge loads the entry register, and the result
// reaches the output register after the seven lane stages (table read, small
// products, coefficient multipliers, two adder stages, scaling/clamp, output
// table read). Sustained rate is one word per cycle while out_ready is high;
// table loads travel the same pipeline, so they take effect in word order.
// Load words and op 3 produce no result. Configuration must be written only
// while idle; the block itself does not enforce this.
module arithmetic_composite_pixel (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [acp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [acp_pkg::COEF_W-1:0]         cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         op,
  input  wire logic [acp_pkg::PIX_W-1:0]          pixel_a,
  input  wire logic [acp_pkg::PIX_W-1:0]          pixel_b,
  input  wire logic [acp_pkg::CH_W-1:0]           table_index,
  input  wire logic [acp_pkg::CH_W-1:0]           table_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [acp_pkg::PIX_W-1:0]               pixel_out
);
  import acp_pkg::*;

  localparam int NS = LANE_STAGES + 1;

  coef_t     coef;
  logic      linear_mode;
  lane_ctl_t ctl;

  logic [NS-1:0] v;
  logic [NS-1:0] free;
  logic [NS-1:0] leaving;
  logic [NS-1:0] load;

  op_t             op_s  [LANE_STAGES];
  logic [CH_W-1:0] idx_s [LANE_STAGES];
  logic [CH_W-1:0] val_s [LANE_STAGES];
  logic [PIX_W-1:0] pa0, pb0;

  logic [CH_W-1:0] res [NUM_LANES];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef        <= '0;
      linear_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COEF_PRODUCT: coef.k1     <= cfg_data;
        REG_COEF_FIRST:   coef.k2     <= cfg_data;
        REG_COEF_SECOND:  coef.k3     <= cfg_data;
        REG_COEF_OFFSET:  coef.k4     <= cfg_data;
        REG_LINEAR_MODE:  linear_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage advance: a stage moves on when the next one is empty or moving
  always_comb begin
    free[NS-1]    = !v[NS-1] || out_ready;
    leaving[NS-1] = v[NS-1] && out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      leaving[k] = v[k] && free[k+1];
      free[k]    = !v[k] || leaving[k];
    end
    load[0] = in_valid && free[0];
    for (int k = 1; k < NS; k++) begin
      load[k] = leaving[k-1];
    end
  end

  assign in_ready = free[0];

  // Valid bits; only pixel words are marked valid in the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (load[k]) begin
          v[k] <= (k == NS - 1) ? (op_s[LANE_STAGES-1] == OP_PIXEL) : 1'b1;
        end else if (leaving[k]) begin
          v[k] <= 1'b0;
        end
      end
    end
  end

  // Entry register and op/table fields carried down the pipe
  always_ff @(posedge clk) begin
    if (load[0]) begin
      op_s[0]  <= op_t'(op);
      idx_s[0] <= table_index;
      val_s[0] <= table_value;
      pa0      <= pixel_a;
      pb0      <= pixel_b;
    end
    for (int k = 1; k < LANE_STAGES; k++) begin
      if (load[k]) begin
        op_s[k]  <= op_s[k-1];
        idx_s[k] <= idx_s[k-1];
        val_s[k] <= val_s[k-1];
      end
    end
  end

  // Lane control
  always_comb begin
    ctl.load     = load[NS-1:1];
    ctl.lin_we   = load[1] && (op_s[0] == OP_LOAD_LIN);
    ctl.lin_idx  = idx_s[0];
    ctl.lin_val  = val_s[0];
    ctl.srgb_we  = load[NS-1] && (op_s[LANE_STAGES-1] == OP_LOAD_SRGB);
    ctl.srgb_idx = idx_s[LANE_STAGES-1];
    ctl.srgb_val = val_s[LANE_STAGES-1];
  end

  // Channel lanes and merge into the output word
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    acp_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .coef   (coef),
      .lin_en (linear_mode && (i != ALPHA_LANE)),
      .a_in   (pa0[i*CH_W +: CH_W]),
      .b_in   (pb0[i*CH_W +: CH_W]),
      .res    (res[i])
    );
    assign pixel_out[i*CH_W +: CH_W] = res[i];
  end

  assign out_valid = v[NS-1];

endmodule

`default_nettype wire
